// ===== rtl/core/dibc_pkg.sv =====
package dibc_pkg;

   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 23;
   localparam int unsigned FRAC_BITS   = 54;
   localparam int unsigned ROOT_IDX_W  = 4;
   localparam int unsigned ROOT_COUNT  = 15;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;
   localparam logic [30:0] HALF_Q30    = 31'd536870912;
   localparam logic [31:0] LOG2E_Q30   = 32'd1549082005;
   localparam logic [16:0] ONE_Q16     = 17'd65536;

   typedef logic signed [71:0] wide_type;
   typedef logic [ROOT_COUNT-1:0][30:0] root_tab_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOW_PLASMA         = 3'd0,
      CSR_EXTRACTION_FRACTION = 3'd1,
      CSR_RATE_POS            = 3'd2,
      CSR_RATE_NEG            = 3'd3,
      CSR_ARTERIAL_FRACTION   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [22:0]        flow_plasma;
      logic [16:0]        extraction_fraction;
      logic [22:0]        rate_pos;
      logic [22:0]        rate_neg;
      logic signed [17:0] arterial_fraction;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MIX_A, S_MIX_V, S_MIX_SUM,
      S_DEC_K, S_DEC_Y, S_DEC_IDX, S_DEC_TAB, S_DEC_RND, S_DEC_SHIFT,
      S_UPD_PREV, S_UPD_S, S_UPD_DT, S_UPD_HI, S_UPD_LO, S_UPD_RES, S_UPD_SUM,
      S_WGT_POS, S_WGT_NEG, S_ACC_PH, S_ACC_PL, S_ACC_NH, S_ACC_NL, S_ACC_LAST,
      S_OUT
   } state_type;

   // Integer square root, used only to build constants at elaboration.
   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = '0;
      b = 64'd1 << 62;
      x = v;
      for (int i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry k is 2^(-2^-k) in Q1.30; entry 0 is one.
   function automatic root_tab_type root_table();
      root_tab_type t;
      logic [63:0] c;
      t = '0;
      t[0] = ONE_Q30;
      c = isqrt64(64'd1 << 59);
      t[1] = c[30:0];
      for (int k = 2; k < ROOT_COUNT; k++) begin
         c = isqrt64({3'd0, t[k-1], 30'd0});
         t[k] = c[30:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = root_table();

   // Shift right with rounding to nearest, ties away from zero.
   function automatic wide_type round_shift(wide_type v, int unsigned n);
      wide_type m;
      wide_type half;
      half = wide_type'(1) <<< (n - 1);
      m = v[71] ? -v : v;
      m = (m + half) >>> n;
      return v[71] ? -m : m;
   endfunction

   function automatic wide_type sat_bits(wide_type v, int unsigned bits);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (bits - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

endpackage

// ===== rtl/core/dibc_channels.sv =====
interface dibc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] time_step;
   logic [23:0] arterial_sample;
   logic [23:0] portal_sample;
   logic        first_sample;
   modport source (output valid, time_step, arterial_sample, portal_sample, first_sample,
                   input ready);
   modport sink   (input valid, time_step, arterial_sample, portal_sample, first_sample,
                   output ready);
endinterface

interface dibc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] tissue_conc;
   modport source (output valid, tissue_conc, input ready);
   modport sink   (input valid, tissue_conc, output ready);
endinterface

interface dibc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [22:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dibc_mul.sv =====
module dibc_mul (
   input  logic               clock,
   input  logic signed [33:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [65:0] prod_ff
);
   // Shared multiplier with a registered product.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end
endmodule

// ===== rtl/core/dibc_csr.sv =====
module dibc_csr (
   input  logic             clock,
   input  logic             reset,
   dibc_csr_if.sink         csr_ch,
   output dibc_pkg::cfg_type cfg
);
   import dibc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flow_plasma         <= 23'd65536;
         cfg_ff.extraction_fraction <= 17'd32768;
         cfg_ff.rate_pos            <= 23'd65536;
         cfg_ff.rate_neg            <= 23'd65536;
         cfg_ff.arterial_fraction   <= 18'sd32768;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_FLOW_PLASMA:         cfg_ff.flow_plasma <= csr_ch.data;
            CSR_EXTRACTION_FRACTION: cfg_ff.extraction_fraction <= csr_ch.data[16:0];
            CSR_RATE_POS:            cfg_ff.rate_pos <= csr_ch.data;
            CSR_RATE_NEG:            cfg_ff.rate_neg <= csr_ch.data;
            CSR_ARTERIAL_FRACTION:   cfg_ff.arterial_fraction <= signed'(csr_ch.data[17:0]);
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/core/dual_input_biexp_convolution_unit.sv =====
// Dual-input two-compartment convolution. Each input transfer carries one time
// sample (time step, arterial and portal concentration, first-sample flag) and
// produces exactly one tissue concentration transfer. All arithmetic runs on a
// single shared 34x32 multiplier under a sequencer, so the block takes one item
// at a time and holds req ready low while it works. A first sample goes from
// the mixing steps straight to the output. For any other sample the time taken
// grows with EXP_TABLE_BITS (10 by default) and with the number of set bits in
// the two decay table indices. The decay 2^-f is built one index bit at a time
// by repeated multiplication by precomputed roots. The result sits in an output
// register, and the block returns to idle once it has been loaded.
// Configuration writes are taken in any cycle and must only be issued while the
// block is idle.
module dual_input_biexp_convolution_unit #(
   parameter int unsigned EXP_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   dibc_req_if.sink    req_ch,
   dibc_rsp_if.source  rsp_ch,
   dibc_csr_if.sink    csr_ch
);
   import dibc_pkg::*;

   localparam int unsigned TB = EXP_TABLE_BITS;
   localparam int unsigned JW = $clog2(TB);

   cfg_type   cfg;
   state_type state_ff, state_in;

   logic                comp_ff;
   logic [19:0]         dt_ff;
   logic [23:0]         ca_ff, cv_ff;
   logic                first_ff;
   wide_type            acc_ff;
   logic signed [31:0]  cp_ff, prev_ff;
   logic signed [39:0]  sum_pos_ff, sum_neg_ff;
   logic [30:0]         e_pos_ff, e_neg_ff, e_work_ff;
   logic [9:0]          n_ff;
   logic [TB-1:0]       idx_lo_ff;
   logic [JW-1:0]       j_ff;
   logic signed [33:0]  s_ff;
   logic signed [35:0]  a_ff;
   logic [50:0]         hi_ff;
   logic signed [41:0]  md_ff;
   logic [23:0]         wpos_ff, wneg_ff;
   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_data_ff;

   logic signed [33:0]  mul_a;
   logic signed [31:0]  mul_b;
   logic signed [65:0]  prod;
   wide_type            prod_w;

   logic [16:0]         e_sat;
   logic signed [18:0]  fv;
   logic [30:0]         e_cur;
   logic signed [39:0]  sum_cur;
   logic [39:0]         sum_mag;
   logic [ROOT_IDX_W-1:0] root_pos;
   logic signed [31:0]  cp_now;
   logic [54:0]         idx_sum;
   logic [51:0]         frac_sum;
   logic [40:0]         res_mag;
   wide_type            w_tmp;
   logic                out_load;

   dibc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   dibc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   // Extraction fraction is clipped to one; venous weight is one minus f_a.
   assign e_sat   = (cfg.extraction_fraction > ONE_Q16) ? ONE_Q16 : cfg.extraction_fraction;
   assign fv      = 19'sd65536 - 19'(cfg.arterial_fraction);
   assign prod_w  = wide_type'(prod);
   assign e_cur   = comp_ff ? e_neg_ff : e_pos_ff;
   assign sum_cur = comp_ff ? sum_neg_ff : sum_pos_ff;
   assign sum_mag = sum_cur[39] ? (~sum_cur + 40'd1) : sum_cur;
   assign root_pos = ROOT_IDX_W'(TB) - ROOT_IDX_W'(j_ff);

   // Mixed input: the two products are added and rounded back to Q12.20.
   assign cp_now = 32'(sat_bits(round_shift(acc_ff + prod_w, 16), 32));

   // Fractional part of the base-two exponent rounded to the table resolution.
   assign idx_sum = {1'b0, prod[FRAC_BITS-1:0]} + (55'd1 << (FRAC_BITS - 1 - TB));

   // Decay of the running sum, in two halves as the high and low products arrive.
   assign frac_sum = {hi_ff[9:0], 20'd0, 22'd0} >> 22;
   assign res_mag  = 41'(hi_ff[50:10])
                   + 41'((52'(frac_sum) + 52'(prod[50:0]) + 52'(HALF_Q30)) >> 30);

   assign w_tmp    = prod_w + wide_type'(32768);
   assign out_load = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.tissue_conc = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_ch.valid) state_in = S_MIX_A;
         S_MIX_A:     state_in = S_MIX_V;
         S_MIX_V:     state_in = S_MIX_SUM;
         S_MIX_SUM:   state_in = first_ff ? S_OUT : S_DEC_K;
         S_DEC_K:     state_in = S_DEC_Y;
         S_DEC_Y:     state_in = S_DEC_IDX;
         S_DEC_IDX:   state_in = S_DEC_TAB;
         S_DEC_TAB: begin
            if (idx_lo_ff[j_ff]) state_in = S_DEC_RND;
            else if (j_ff == '0) state_in = S_DEC_SHIFT;
         end
         S_DEC_RND:   state_in = (j_ff == '0) ? S_DEC_SHIFT : S_DEC_TAB;
         S_DEC_SHIFT: state_in = comp_ff ? S_UPD_PREV : S_DEC_K;
         S_UPD_PREV:  state_in = S_UPD_S;
         S_UPD_S:     state_in = S_UPD_DT;
         S_UPD_DT:    state_in = S_UPD_HI;
         S_UPD_HI:    state_in = S_UPD_LO;
         S_UPD_LO:    state_in = S_UPD_RES;
         S_UPD_RES:   state_in = S_UPD_SUM;
         S_UPD_SUM:   state_in = comp_ff ? S_WGT_POS : S_UPD_PREV;
         S_WGT_POS:   state_in = S_WGT_NEG;
         S_WGT_NEG:   state_in = S_ACC_PH;
         S_ACC_PH:    state_in = S_ACC_PL;
         S_ACC_PL:    state_in = S_ACC_NH;
         S_ACC_NH:    state_in = S_ACC_NL;
         S_ACC_NL:    state_in = S_ACC_LAST;
         S_ACC_LAST:  state_in = S_OUT;
         S_OUT:       if (out_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Multiplier operands for the step in hand.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MIX_A: begin
            mul_a = 34'(cfg.arterial_fraction);
            mul_b = 32'(ca_ff);
         end
         S_MIX_V: begin
            mul_a = 34'(fv);
            mul_b = 32'(cv_ff);
         end
         S_DEC_K: begin
            mul_a = 34'(comp_ff ? cfg.rate_neg : cfg.rate_pos);
            mul_b = 32'(dt_ff);
         end
         S_DEC_Y: begin
            mul_a = {1'b0, prod[42:10]};
            mul_b = LOG2E_Q30;
         end
         S_DEC_TAB: begin
            mul_a = 34'(e_work_ff);
            mul_b = 32'(ROOT_TAB[root_pos]);
         end
         S_UPD_PREV: begin
            mul_a = 34'(prev_ff);
            mul_b = 32'(e_cur);
         end
         S_UPD_DT: begin
            mul_a = s_ff;
            mul_b = 32'(dt_ff);
         end
         S_UPD_HI: begin
            mul_a = 34'(sum_mag[39:20]);
            mul_b = 32'(e_cur);
         end
         S_UPD_LO: begin
            mul_a = 34'(sum_mag[19:0]);
            mul_b = 32'(e_cur);
         end
         S_WGT_POS: begin
            mul_a = 34'(cfg.flow_plasma);
            mul_b = 32'(e_sat);
         end
         S_WGT_NEG: begin
            mul_a = 34'(cfg.flow_plasma);
            mul_b = 32'(ONE_Q16 - e_sat);
         end
         // The upper half of each sum carries its sign; the lower half is a
         // plain magnitude.
         S_ACC_PH: begin
            mul_a = 34'(wpos_ff);
            mul_b = 32'(signed'(sum_pos_ff[39:20]));
         end
         S_ACC_PL: begin
            mul_a = 34'(wpos_ff);
            mul_b = 32'(sum_pos_ff[19:0]);
         end
         S_ACC_NH: begin
            mul_a = 34'(wneg_ff);
            mul_b = 32'(signed'(sum_neg_ff[39:20]));
         end
         S_ACC_NL: begin
            mul_a = 34'(wneg_ff);
            mul_b = 32'(sum_neg_ff[19:0]);
         end
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         sum_pos_ff   <= '0;
         sum_neg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_MIX_SUM: begin
               comp_ff <= 1'b0;
               if (first_ff) begin
                  sum_pos_ff <= '0;
                  sum_neg_ff <= '0;
                  prev_ff    <= cp_now;
               end
            end
            S_DEC_SHIFT: comp_ff <= !comp_ff;
            S_UPD_SUM: begin
               if (comp_ff) begin
                  sum_neg_ff <= 40'(sat_bits(wide_type'(md_ff) + wide_type'(a_ff), 40));
                  prev_ff    <= cp_ff;
               end else begin
                  sum_pos_ff <= 40'(sat_bits(wide_type'(md_ff) + wide_type'(a_ff), 40));
               end
               comp_ff <= !comp_ff;
            end
            default: ;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            dt_ff    <= req_ch.time_step;
            ca_ff    <= req_ch.arterial_sample;
            cv_ff    <= req_ch.portal_sample;
            first_ff <= req_ch.first_sample;
         end
         S_MIX_V:   acc_ff <= prod_w;
         S_MIX_SUM: begin
            cp_ff <= cp_now;
            if (first_ff) acc_ff <= '0;
         end
         S_DEC_IDX: begin
            n_ff       <= prod[63:54];
            idx_lo_ff  <= idx_sum[53 -: TB];
            e_work_ff  <= idx_sum[54] ? HALF_Q30 : ONE_Q30;
            j_ff       <= JW'(TB - 1);
         end
         S_DEC_TAB: begin
            if (!idx_lo_ff[j_ff] && j_ff != '0) j_ff <= j_ff - 1'b1;
         end
         S_DEC_RND: begin
            e_work_ff <= 31'(round_shift(prod_w, 30));
            if (j_ff != '0) j_ff <= j_ff - 1'b1;
         end
         S_DEC_SHIFT: begin
            if (comp_ff) e_neg_ff <= (n_ff > 10'd30) ? '0 : (e_work_ff >> n_ff);
            else         e_pos_ff <= (n_ff > 10'd30) ? '0 : (e_work_ff >> n_ff);
         end
         S_UPD_S:   s_ff  <= 34'(wide_type'(cp_ff) + round_shift(prod_w, 30));
         S_UPD_HI:  a_ff  <= 36'(round_shift(prod_w, 19));
         S_UPD_LO:  hi_ff <= prod[50:0];
         S_UPD_RES: md_ff <= sum_cur[39] ? -42'(res_mag) : 42'(res_mag);
         S_WGT_NEG: wpos_ff <= w_tmp[39:16];
         S_ACC_PH:  wneg_ff <= w_tmp[39:16];
         S_ACC_PL:  acc_ff <= prod_w <<< 20;
         S_ACC_NH:  acc_ff <= acc_ff + prod_w;
         S_ACC_NL:  acc_ff <= acc_ff + (prod_w <<< 20);
         S_ACC_LAST: acc_ff <= acc_ff + prod_w;
         S_OUT: begin
            if (out_load) rsp_data_ff <= 32'(sat_bits(round_shift(acc_ff, 16), 32));
         end
         default: ;
      endcase
   end

   // A first sample clears both running sums and yields a zero result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIX_SUM && first_ff) |=> (sum_pos_ff == 0 && sum_neg_ff == 0 &&
                                               acc_ff == 0 && state_ff == S_OUT))
      else $error("first sample did not restart the series");

   // The positive compartment decay factor never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC_SHIFT && !comp_ff) |=> (e_pos_ff <= ONE_Q30))
      else $error("positive compartment decay above one");

   // A finished result waits in the output stage while the previous one is held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_OUT))
      else $error("result overwrote a pending transfer");

endmodule
